@@ design/topq_pkg.sv @@
package topq_pkg;

   localparam int STAMP_W             = 64;
   localparam int TAG_W               = 16;
   localparam int COUNT_OUT_W         = 5;
   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POP    = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_WRITE,
      ST_POP
   } state_type;

   typedef struct packed {
      logic [STAMP_W-1:0] pres;
      logic [STAMP_W-1:0] dec;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   typedef struct packed {
      logic                   strobe;
      logic [1:0]             status;
      logic [COUNT_OUT_W-1:0] count;
      logic                   valid;
      entry_type              entry;
   } rsp_type;

endpackage

@@ design/topq_mem.sv @@
module topq_mem #(
   parameter int QUEUE_DEPTH = topq_pkg::DEFAULT_QUEUE_DEPTH,
   localparam int AW = $clog2(QUEUE_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  topq_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output topq_pkg::entry_type rd_data
);

   topq_pkg::entry_type mem [QUEUE_DEPTH];
   topq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/topq_ctrl.sv @@
module topq_ctrl #(
   parameter int QUEUE_DEPTH = topq_pkg::DEFAULT_QUEUE_DEPTH,
   localparam int AW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_type,
   input  topq_pkg::entry_type req_entry,
   input  logic                sort_by_dec,
   output logic                busy,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output topq_pkg::entry_type mem_wr_data,
   output logic [AW-1:0]       mem_rd_addr,
   input  topq_pkg::entry_type mem_rd_data,
   output topq_pkg::rsp_type   rsp_in
);

   localparam int AWP = AW + 1;
   localparam logic [AW:0] DEPTH_W = AWP'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   topq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       pos_ff, pos_in;
   topq_pkg::entry_type new_ff, new_in;

   logic [topq_pkg::STAMP_W-1:0] rd_key, new_key;
   logic                         greater;
   logic                         last_scan;
   logic [CW+topq_pkg::COUNT_OUT_W-1:0] count_ext;
   logic [CW-1:0]                rsp_count;

   // Physical slot of logical position off, ring starting at head.
   function automatic logic [AW-1:0] ring(input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, head_ff} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   assign rd_key    = sort_by_dec ? mem_rd_data.dec : mem_rd_data.pres;
   assign new_key   = sort_by_dec ? new_ff.dec : new_ff.pres;
   assign greater   = $signed(rd_key) > $signed(new_key);
   assign last_scan = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign busy      = state_ff != topq_pkg::ST_IDLE;
   assign count_ext = {{topq_pkg::COUNT_OUT_W{1'b0}}, rsp_count};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         topq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == topq_pkg::REQ_INSERT) begin
                  if (count_ff == DEPTH_C) begin
                     state_in = topq_pkg::ST_IDLE;
                  end else if (count_ff == '0) begin
                     state_in = topq_pkg::ST_WRITE;
                  end else begin
                     state_in = topq_pkg::ST_SCAN;
                  end
               end else begin
                  state_in = (count_ff == '0) ? topq_pkg::ST_IDLE : topq_pkg::ST_POP;
               end
            end
         end
         topq_pkg::ST_SCAN: begin
            priority if (greater) begin
               state_in = topq_pkg::ST_SHIFT;
            end else if (last_scan) begin
               state_in = topq_pkg::ST_WRITE;
            end
         end
         topq_pkg::ST_SHIFT: begin
            if (idx_ff == pos_ff) begin
               state_in = topq_pkg::ST_WRITE;
            end
         end
         topq_pkg::ST_WRITE: state_in = topq_pkg::ST_IDLE;
         topq_pkg::ST_POP:   state_in = topq_pkg::ST_IDLE;
         default:            state_in = topq_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      new_in      = new_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ring(pos_ff);
      mem_wr_data = new_ff;
      mem_rd_addr = ring('0);
      rsp_count   = count_ff;
      rsp_in      = '0;
      unique case (state_ff)
         topq_pkg::ST_IDLE: begin
            if (start) begin
               new_in = req_entry;
               idx_in = '0;
               pos_in = '0;
               if (req_type == topq_pkg::REQ_INSERT) begin
                  if (count_ff == DEPTH_C) begin
                     rsp_in.strobe = 1'b1;
                     rsp_in.status = topq_pkg::STATUS_FULL;
                  end
               end else if (count_ff == '0) begin
                  rsp_in.strobe = 1'b1;
                  rsp_in.status = topq_pkg::STATUS_EMPTY;
               end
            end
         end
         topq_pkg::ST_SCAN: begin
            priority if (greater) begin
               // insert here; start moving the tail down from the last entry
               pos_in      = idx_ff;
               idx_in      = AW'(count_ff - CW'(1));
               mem_rd_addr = ring(AW'(count_ff - CW'(1)));
            end else if (last_scan) begin
               pos_in = AW'(count_ff);
            end else begin
               idx_in      = idx_ff + AW'(1);
               mem_rd_addr = ring(idx_ff + AW'(1));
            end
         end
         topq_pkg::ST_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ring(idx_ff + AW'(1));
            mem_wr_data = mem_rd_data;
            if (idx_ff != pos_ff) begin
               idx_in      = idx_ff - AW'(1);
               mem_rd_addr = ring(idx_ff - AW'(1));
            end
         end
         topq_pkg::ST_WRITE: begin
            mem_wr_en     = 1'b1;
            count_in      = count_ff + CW'(1);
            rsp_count     = count_in;
            rsp_in.strobe = 1'b1;
            rsp_in.status = topq_pkg::STATUS_OK;
         end
         topq_pkg::ST_POP: begin
            count_in      = count_ff - CW'(1);
            head_in       = ring(AW'(1));
            rsp_count     = count_in;
            rsp_in.strobe = 1'b1;
            rsp_in.status = topq_pkg::STATUS_OK;
            rsp_in.valid  = 1'b1;
            rsp_in.entry  = mem_rd_data;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.count = count_ext[topq_pkg::COUNT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= topq_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      new_ff <= new_in;
   end

endmodule

@@ design/timestamp_ordered_packet_queue.sv @@
// Timestamp-ordered packet queue: packet descriptors (presentation stamp,
// decode stamp, buffer tag) kept sorted by one stamp, stored as a ring in a
// single RAM of QUEUE_DEPTH entries with a registered read.
// Request channel: a transaction is taken at a clock edge with start high
// and busy low. req_type selects insert or pop; stamps and tag ride along.
// Response channel: exactly one transaction per request, shown for one
// cycle with rsp_strobe high; the receiver cannot stall it, so it is never
// held. Non-pop results carry zero on the popped-entry fields.
// Steps, per request kind:
//   full insert or empty pop: result in the next cycle, busy not raised.
//   pop: head read, then ring head advances (no data moves).
//   insert: the scan reads one entry per cycle until the first strictly
//   greater key (or to the end when none), then the tail moves down one
//   slot per cycle (skipped when appending), then the new entry is written;
//   then the result is registered.
//   The single RAM read and write port sets this order.
// A new request is taken in the cycle its predecessor's result is shown.
// Reset (synchronous) empties the queue and selects presentation-stamp
// ordering; RAM contents are not cleared. csr_wr_data picks the key (1 =
// decode stamp); users write it only while the block is idle (unchecked).
module timestamp_ordered_packet_queue #(
   parameter int QUEUE_DEPTH = topq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic signed [topq_pkg::STAMP_W-1:0] req_in_pres_stamp,
   input  logic signed [topq_pkg::STAMP_W-1:0] req_in_dec_stamp,
   input  logic [topq_pkg::TAG_W-1:0]          req_in_tag,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [topq_pkg::COUNT_OUT_W-1:0]     rsp_entry_count,
   output logic        rsp_out_valid,
   output logic signed [topq_pkg::STAMP_W-1:0] rsp_out_pres_stamp,
   output logic signed [topq_pkg::STAMP_W-1:0] rsp_out_dec_stamp,
   output logic [topq_pkg::TAG_W-1:0]          rsp_out_tag
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic                sort_by_dec_ff;
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [AW-1:0]       mem_rd_addr;
   topq_pkg::entry_type mem_wr_data;
   topq_pkg::entry_type mem_rd_data;
   topq_pkg::entry_type req_entry;
   topq_pkg::rsp_type   rsp_in;
   topq_pkg::rsp_type   rsp_ff;

   assign req_entry.pres = req_in_pres_stamp;
   assign req_entry.dec  = req_in_dec_stamp;
   assign req_entry.tag  = req_in_tag;

   // sort-key select register
   always_ff @(posedge clock) begin
      if (reset) begin
         sort_by_dec_ff <= 1'b0;
      end else if (csr_wr_en) begin
         sort_by_dec_ff <= csr_wr_data;
      end
   end

   topq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_type    (req_type),
      .req_entry   (req_entry),
      .sort_by_dec (sort_by_dec_ff),
      .busy        (busy),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_in      (rsp_in)
   );

   topq_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result register: strobe is control, the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.strobe <= 1'b0;
      end else begin
         rsp_ff.strobe <= rsp_in.strobe;
      end
      if (rsp_in.strobe) begin
         rsp_ff.status <= rsp_in.status;
         rsp_ff.count  <= rsp_in.count;
         rsp_ff.valid  <= rsp_in.valid;
         rsp_ff.entry  <= rsp_in.entry;
      end
   end

   assign rsp_strobe         = rsp_ff.strobe;
   assign rsp_status         = rsp_ff.status;
   assign rsp_entry_count    = rsp_ff.count;
   assign rsp_out_valid      = rsp_ff.valid;
   assign rsp_out_pres_stamp = rsp_ff.entry.pres;
   assign rsp_out_dec_stamp  = rsp_ff.entry.dec;
   assign rsp_out_tag        = rsp_ff.entry.tag;

endmodule
